/* design/fqrv_pkg.sv */
// Shared types and constants for the compacting FIFO with remove-by-value.
// Standalone package; used by fqrv_ctrl, fqrv_dpath and the top level.
package fqrv_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned IDX_W       = $clog2(DEPTH);
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned CAP_W       = 5;
  localparam int unsigned OCC_W       = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH   = 3'd0,
    FN_POP    = 3'd1,
    FN_PEEK   = 3'd2,
    FN_LIST   = 3'd3,
    FN_REMOVE = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } stat_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PUSH,
    ACT_POP,
    ACT_PEEK,
    ACT_LIST,
    ACT_REMOVE,
    ACT_NOP
  } act_e;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_e;

  typedef struct packed {
    act_e act;
    logic list_first;
  } cmd_t;

  typedef struct packed {
    logic more_first;
    logic more_next;
  } dp_stat_t;

endpackage

/* design/fqrv_ctrl.sv */
// Controller FSM: decodes operations and sequences multi-beat list output.
// Depends on fqrv_pkg.
module fqrv_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic [fqrv_pkg::FUNC_W-1:0]   func_i,
  input  fqrv_pkg::dp_stat_t            dp_stat_i,
  output logic                          busy,
  output fqrv_pkg::cmd_t                cmd_o
);

  fqrv_pkg::state_e state_q, state_d;
  logic             accept;

  assign accept = start && (state_q == fqrv_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fqrv_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fqrv_pkg::S_IDLE: begin
        if (accept && (fqrv_pkg::func_e'(func_i) == fqrv_pkg::FN_LIST) &&
            dp_stat_i.more_first) begin
          state_d = fqrv_pkg::S_LIST;
        end
      end
      fqrv_pkg::S_LIST: begin
        if (!dp_stat_i.more_next) begin
          state_d = fqrv_pkg::S_IDLE;
        end
      end
      default: state_d = fqrv_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy              = 1'b0;
    cmd_o.act         = fqrv_pkg::ACT_NONE;
    cmd_o.list_first  = 1'b0;
    unique case (state_q)
      fqrv_pkg::S_IDLE: begin
        if (accept) begin
          unique case (fqrv_pkg::func_e'(func_i))
            fqrv_pkg::FN_PUSH:   cmd_o.act = fqrv_pkg::ACT_PUSH;
            fqrv_pkg::FN_POP:    cmd_o.act = fqrv_pkg::ACT_POP;
            fqrv_pkg::FN_PEEK:   cmd_o.act = fqrv_pkg::ACT_PEEK;
            fqrv_pkg::FN_LIST: begin
              cmd_o.act        = fqrv_pkg::ACT_LIST;
              cmd_o.list_first = 1'b1;
            end
            fqrv_pkg::FN_REMOVE: cmd_o.act = fqrv_pkg::ACT_REMOVE;
            default:             cmd_o.act = fqrv_pkg::ACT_NOP;
          endcase
        end
      end
      fqrv_pkg::S_LIST: begin
        busy      = 1'b1;
        cmd_o.act = fqrv_pkg::ACT_LIST;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

/* design/fqrv_dpath.sv */
// Datapath: compacting cell array, count, capacity register, result registers.
// Depends on fqrv_pkg; driven by fqrv_ctrl commands.
module fqrv_dpath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fqrv_pkg::CAP_W-1:0]         cfg_wdata_i,
  input  logic signed [fqrv_pkg::WORD_W-1:0] value_i,
  input  fqrv_pkg::cmd_t                     cmd_i,
  output fqrv_pkg::dp_stat_t                 stat_o,
  output logic signed [fqrv_pkg::WORD_W-1:0] data_o,
  output logic [1:0]                         status_o,
  output logic [fqrv_pkg::OCC_W-1:0]         occupancy_o,
  output logic                               last_o,
  output logic                               strobe_o
);

  logic signed [fqrv_pkg::WORD_W-1:0] cells_q [fqrv_pkg::DEPTH];
  logic signed [fqrv_pkg::WORD_W-1:0] cells_up [fqrv_pkg::DEPTH];

  logic [fqrv_pkg::CNT_W-1:0] count_q, count_d;
  logic [fqrv_pkg::CAP_W-1:0] cap_q;
  logic [fqrv_pkg::IDX_W-1:0] lidx_q, lidx_d, rd_idx, wr_idx;

  logic signed [fqrv_pkg::WORD_W-1:0] data_q, data_d;
  fqrv_pkg::stat_e                    status_q, status_d;
  logic [fqrv_pkg::OCC_W-1:0]         occ_q;
  logic                               last_q, last_d;
  logic                               strobe_q, strobe_d;

  logic                       full, empty, found, rd_last;
  logic                       push_en, shift_en, pop_sel;
  logic [31:0]                n_lst;
  logic [fqrv_pkg::DEPTH-1:0] match, sh;

  assign full  = (32'(count_q) >= 32'(cap_q)) || (32'(count_q) >= fqrv_pkg::DEPTH);
  assign empty = (count_q == '0);
  assign n_lst = (32'(count_q) < fqrv_pkg::MAX_RESULTS) ? 32'(count_q)
                                                         : fqrv_pkg::MAX_RESULTS;

  assign rd_idx  = cmd_i.list_first ? '0 : lidx_q;
  assign rd_last = (32'(rd_idx) + 32'd1) >= n_lst;
  assign wr_idx  = count_q[fqrv_pkg::IDX_W-1:0];

  assign stat_o.more_first = n_lst > 32'd1;
  assign stat_o.more_next  = (32'(lidx_q) + 32'd1) < n_lst;

  always_comb begin
    for (int i = 0; i < fqrv_pkg::DEPTH; i++) begin
      match[i] = (cells_q[i] == value_i) && (32'(i) < 32'(count_q));
    end
  end

  assign found = |match;

  // ones from the first match upward; all ones on a pop
  always_comb begin
    sh = match;
    for (int k = 1; k < fqrv_pkg::DEPTH; k = k * 2) begin
      sh = sh | (sh << k);
    end
    if (pop_sel) begin
      sh = '1;
    end
  end

  always_comb begin
    for (int i = 0; i < fqrv_pkg::DEPTH - 1; i++) begin
      cells_up[i] = cells_q[i + 1];
    end
    cells_up[fqrv_pkg::DEPTH-1] = cells_q[fqrv_pkg::DEPTH-1];
  end

  always_comb begin
    count_d  = count_q;
    lidx_d   = lidx_q;
    push_en  = 1'b0;
    shift_en = 1'b0;
    pop_sel  = 1'b0;
    data_d   = '0;
    status_d = fqrv_pkg::ST_OK;
    last_d   = 1'b1;
    strobe_d = 1'b1;
    unique case (cmd_i.act)
      fqrv_pkg::ACT_NONE: begin
        strobe_d = 1'b0;
      end
      fqrv_pkg::ACT_PUSH: begin
        if (full) begin
          status_d = fqrv_pkg::ST_FULL;
        end else begin
          push_en = 1'b1;
          count_d = count_q + fqrv_pkg::CNT_W'(1);
          data_d  = value_i;
        end
      end
      fqrv_pkg::ACT_POP: begin
        if (empty) begin
          status_d = fqrv_pkg::ST_EMPTY;
        end else begin
          pop_sel  = 1'b1;
          shift_en = 1'b1;
          count_d  = count_q - fqrv_pkg::CNT_W'(1);
          data_d   = cells_q[0];
        end
      end
      fqrv_pkg::ACT_PEEK: begin
        if (empty) begin
          status_d = fqrv_pkg::ST_EMPTY;
        end else begin
          data_d = cells_q[0];
        end
      end
      fqrv_pkg::ACT_LIST: begin
        if (empty) begin
          status_d = fqrv_pkg::ST_EMPTY;
        end else begin
          data_d = cells_q[rd_idx];
          last_d = rd_last;
          lidx_d = rd_idx + fqrv_pkg::IDX_W'(1);
        end
      end
      fqrv_pkg::ACT_REMOVE: begin
        if (empty) begin
          status_d = fqrv_pkg::ST_EMPTY;
        end else if (found) begin
          shift_en = 1'b1;
          count_d  = count_q - fqrv_pkg::CNT_W'(1);
          data_d   = value_i;
        end else begin
          status_d = fqrv_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        data_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < fqrv_pkg::DEPTH; i++) begin
      if (push_en && (wr_idx == fqrv_pkg::IDX_W'(i))) begin
        cells_q[i] <= value_i;
      end else if (shift_en && sh[i]) begin
        cells_q[i] <= cells_up[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cap_q    <= fqrv_pkg::CAP_RESET;
      lidx_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      lidx_q   <= lidx_d;
      strobe_q <= strobe_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q   <= data_d;
    status_q <= status_d;
    occ_q    <= fqrv_pkg::OCC_W'(count_d);
    last_q   <= last_d;
  end

  assign data_o      = data_q;
  assign status_o    = status_q;
  assign occupancy_o = occ_q;
  assign last_o      = last_q;
  assign strobe_o    = strobe_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= fqrv_pkg::DEPTH)
    else $error("count beyond depth");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && (status_q != fqrv_pkg::ST_OK) |-> (data_q == '0))
    else $error("error beat carries nonzero data");

  a_push_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.act == fqrv_pkg::ACT_PUSH) && !full |=>
      (count_q == $past(count_q) + fqrv_pkg::CNT_W'(1)))
    else $error("accepted push did not grow the queue");

  a_list_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.act == fqrv_pkg::ACT_LIST) && !empty |=>
      strobe_q && (status_q == fqrv_pkg::ST_OK))
    else $error("list step gave no ok beat");

endmodule

/* design/fifo_queue_with_remove_by_value.sv */
// Compacting FIFO of signed words with remove-by-value; top level over fqrv_ctrl/fqrv_dpath.
// Each result beat is registered and appears in the cycle after the operation is accepted.
// Push, pop, peek and remove never raise busy (cells shift in parallel);
// a list of n entries gives n beats back to back, with busy high for all but the first.
// The receiver cannot stall: every beat is held for exactly one cycle under strobe_o.
// Reset empties the queue and sets capacity to 16; cell contents are not cleared.
module fifo_queue_with_remove_by_value (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [fqrv_pkg::FUNC_W-1:0]        func_i,
  input  logic signed [fqrv_pkg::WORD_W-1:0] value_i,
  input  logic                               cfg_we_i,
  input  logic [fqrv_pkg::CAP_W-1:0]         cfg_wdata_i,
  output logic                               strobe_o,
  output logic signed [fqrv_pkg::WORD_W-1:0] data_o,
  output logic [1:0]                         status_o,
  output logic [fqrv_pkg::OCC_W-1:0]         occupancy_o,
  output logic                               last_o
);

  fqrv_pkg::cmd_t     cmd;
  fqrv_pkg::dp_stat_t dp_stat;

  fqrv_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .func_i    (func_i),
    .dp_stat_i (dp_stat),
    .busy      (busy),
    .cmd_o     (cmd)
  );

  fqrv_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .stat_o      (dp_stat),
    .data_o      (data_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o),
    .last_o      (last_o),
    .strobe_o    (strobe_o)
  );

endmodule
